// ===== sv/crcfpb_pkg.sv =====
`timescale 1ns / 1ps
// crcfpb_pkg: shared types, framing constants and the CRC-16 byte update
// for the CRC framed packet builder. No dependencies.
package crcfpb_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] amplitude;
    logic [7:0]  depth_cm;
    logic [7:0]  confidence;
    logic [7:0]  target_kind;
    logic [15:0] voice_word;
    logic [15:0] magnitude;
    logic [15:0] pulse_value;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } request_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } result_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic nonempty;
  } queue_status_t;

  localparam logic [1:0] ACT_TARGET  = 2'd0;
  localparam logic [1:0] ACT_VOICE   = 2'd1;
  localparam logic [1:0] ACT_SPATIAL = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  localparam logic [7:0] TYPE_TARGET  = 8'h10;
  localparam logic [7:0] TYPE_VOICE   = 8'h20;
  localparam logic [7:0] TYPE_SPATIAL = 8'h30;

  localparam logic [7:0]  PKT_START   = 8'hAA;
  localparam logic [7:0]  PKT_VERSION = 8'h07;
  localparam logic [7:0]  XOR_BASE    = 8'h5F;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int          HDR_BYTES   = 3;

  // Q7.8 metres to centimetres scale
  localparam logic signed [7:0] POS_SCALE = 8'sd100;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/crc_framed_packet_builder.sv =====
`timescale 1ns / 1ps
// crc_framed_packet_builder: top level, front end, descriptor queue and
// serializer. Depends on crcfpb_pkg, crcfpb_front, crcfpb_queue, crcfpb_back.

// Each accepted request (start high while busy is low) produces one packet of
// PAYLOAD_BYTES + 5 bytes on result, one byte per cycle with strobe high and
// last_byte set on the final CRC byte: AA, 07, type, the whitened payload and
// the Modbus CRC-16 low byte first. The serializer emits one byte a cycle, and
// packets follow each other with no gap while another descriptor is queued.
// When the serializer is free, a request goes through the queue entry, the
// active and idx registers and then the result register. A request
// with action 3 is taken and produces nothing. Up to two requests wait in a
// queue behind the packet in flight; busy is high only while that queue is
// full. The receiver cannot stall: every byte is on the ports for one cycle.
module crc_framed_packet_builder
  import crcfpb_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 12
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output result_t  result,
  output logic     strobe
);

  localparam int DESC_W = 8 * PAYLOAD_BYTES + 8;

  logic                push;
  logic                pop;
  logic [DESC_W-1:0]   wr_desc;
  logic [DESC_W-1:0]   rd_desc;
  queue_status_t       qstat;

  // front end: accept, classify, pack and whiten the payload
  crcfpb_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .start   (start),
    .request (request),
    .qstat   (qstat),
    .busy    (busy),
    .push    (push),
    .desc    (wr_desc)
  );

  // decouples acceptance from the serializer
  crcfpb_queue #(
    .WIDTH(DESC_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_desc),
    .pop     (pop),
    .rd_data (rd_desc),
    .qstat   (qstat)
  );

  // back end: byte serializer with running CRC
  crcfpb_back #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .desc   (rd_desc),
    .pop    (pop),
    .result (result),
    .strobe (strobe)
  );

`ifndef NO_ASSERTIONS
  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("descriptor queue overflow");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.nonempty)
    else $error("descriptor queue underflow");

  // a packet streams without gaps until its last byte
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_byte |=> strobe)
    else $error("gap inside packet");

  // a byte right after a packet end starts a new packet
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_byte |=> !strobe || (result.tx_byte == PKT_START))
    else $error("packet does not open with start byte");
`endif

endmodule

// ===== sv/crcfpb_front.sv =====
`timescale 1ns / 1ps
// crcfpb_front: accepts frame requests, picks the type byte and builds the
// whitened payload. Depends on crcfpb_pkg.
module crcfpb_front
  import crcfpb_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 12
) (
  input  logic                         start,
  input  request_t                     request,
  input  queue_status_t                qstat,
  output logic                         busy,
  output logic                         push,
  output logic [8*PAYLOAD_BYTES+7:0]   desc
);

  logic [7:0]                   type_byte;
  logic [8*PAYLOAD_BYTES-1:0]   raw;
  logic [8*PAYLOAD_BYTES-1:0]   payload;
  logic signed [22:0]           prod_x, prod_y, adj_x, adj_y;
  logic [15:0]                  cm_x, cm_y;

  assign busy = qstat.full;
  // an undefined action is taken and dropped
  assign push = start && !qstat.full && (request.action != ACT_NONE);

  // v*100/256 rounded toward zero: bias negatives by 255 before the shift
  always_comb begin
    prod_x = 23'($signed(request.pos_x)) * 23'(POS_SCALE);
    prod_y = 23'($signed(request.pos_y)) * 23'(POS_SCALE);
    adj_x  = prod_x + (prod_x[22] ? 23'sd255 : 23'sd0);
    adj_y  = prod_y + (prod_y[22] ? 23'sd255 : 23'sd0);
    cm_x   = {adj_x[22], adj_x[22:8]};
    cm_y   = {adj_y[22], adj_y[22:8]};
  end

  always_comb begin
    raw       = '0;
    type_byte = TYPE_SPATIAL;
    case (request.action)
      ACT_TARGET: begin
        type_byte    = TYPE_TARGET;
        raw[15:0]    = request.amplitude;
        raw[23:16]   = request.depth_cm;
        raw[31:24]   = request.confidence;
        raw[39:32]   = request.target_kind;
      end
      ACT_VOICE: begin
        type_byte    = TYPE_VOICE;
        raw[15:0]    = request.voice_word;
      end
      ACT_SPATIAL: begin
        type_byte    = TYPE_SPATIAL;
        raw[15:0]    = request.magnitude;
        raw[31:16]   = request.pulse_value;
        raw[47:32]   = cm_x;
        raw[63:48]   = cm_y;
      end
      default: begin
        type_byte    = TYPE_SPATIAL;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      payload[i*8 +: 8] = raw[i*8 +: 8] ^ (XOR_BASE + 8'(i));
    end
  end

  assign desc = {payload, type_byte};

endmodule

// ===== sv/crcfpb_queue.sv =====
`timescale 1ns / 1ps
// crcfpb_queue: two-entry descriptor queue between front and back ends.
// Depends on crcfpb_pkg.
module crcfpb_queue
  import crcfpb_pkg::*;
#(
  parameter int WIDTH = 104
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   rd_data,
  output queue_status_t      qstat
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rd_data       = mem[rd_ptr];
  assign qstat.full     = (count == 2'd2);
  assign qstat.nonempty = (count != 2'd0);

endmodule

// ===== sv/crcfpb_back.sv =====
`timescale 1ns / 1ps
// crcfpb_back: serializes one packet per descriptor, one byte a cycle,
// running the CRC alongside. Depends on crcfpb_pkg.
module crcfpb_back
  import crcfpb_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  queue_status_t               qstat,
  input  logic [8*PAYLOAD_BYTES+7:0]  desc,
  output logic                        pop,
  output result_t                     result,
  output logic                        strobe
);

  localparam int PKT_BYTES = HDR_BYTES + PAYLOAD_BYTES + 2;
  localparam int IDX_W     = $clog2(PKT_BYTES);
  localparam logic [IDX_W-1:0] IDX_PL_FIRST = IDX_W'(HDR_BYTES);
  localparam logic [IDX_W-1:0] IDX_CRC_LO   = IDX_W'(HDR_BYTES + PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(PKT_BYTES - 1);

  logic                        active;
  logic [IDX_W-1:0]            idx;
  logic [15:0]                 crc;
  logic [7:0]                  type_q;
  logic [8*PAYLOAD_BYTES-1:0]  pl_sr;
  logic [7:0]                  cur_byte;
  logic                        last;
  logic                        in_payload;

  assign last       = active && (idx == IDX_LAST);
  assign in_payload = (idx >= IDX_PL_FIRST) && (idx < IDX_CRC_LO);
  assign pop        = qstat.nonempty && (!active || last);

  always_comb begin
    if (idx == IDX_W'(0))               cur_byte = PKT_START;
    else if (idx == IDX_W'(1))          cur_byte = PKT_VERSION;
    else if (idx == IDX_W'(2))          cur_byte = type_q;
    else if (in_payload)                cur_byte = pl_sr[7:0];
    else if (idx == IDX_CRC_LO)         cur_byte = crc[7:0];
    else                                cur_byte = crc[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (active) begin
        idx <= idx + IDX_W'(1);
        if (last) active <= 1'b0;
      end
    end
  end

  // payload and CRC datapath
  always_ff @(posedge clk) begin
    result.tx_byte   <= cur_byte;
    result.last_byte <= last;
    if (pop) begin
      type_q <= desc[7:0];
      pl_sr  <= desc[8*PAYLOAD_BYTES+7:8];
      crc    <= CRC_INIT;
    end else if (active) begin
      if (idx < IDX_CRC_LO) crc <= crc_update(crc, cur_byte);
      if (in_payload)      pl_sr <= pl_sr >> 8;
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for crc_framed_packet_builder. It drives frame requests as
// command transactions and checks every emitted byte against a local packet model.
// Depends on crcfpb_pkg and the crc_framed_packet_builder RTL.
module tb
  import crcfpb_pkg::*;
();

  localparam int PAYLOAD_LEN     = 12;
  localparam int FRAME_LEN       = HDR_BYTES + PAYLOAD_LEN + 2;
  localparam int RANDOM_REQUESTS = 330;
  localparam int NUM_DIRECTED    = 17;
  // longest legal quiet stretch: three queued packets plus a sender gap, far below this
  localparam int STALL_LIMIT     = 2000;
  // give stray output time to show up
  localparam int DRAIN_CYCLES    = 24;
  localparam int MAX_REPORTS     = 10;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  logic     strobe;
  request_t request;
  result_t  result;

  int unsigned gap_pct;        // chance per cycle that the sender holds start low
  int unsigned mismatch_count;
  int unsigned bytes_seen;
  result_t     packet_bytes_due[$];

  crc_framed_packet_builder #(
    .PAYLOAD_BYTES(PAYLOAD_LEN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .result (result),
    .strobe (strobe)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed table. Fields that the frame kind does not use carry junk in some rows
  // to show they are ignored. The silent column is the typed-in expectation for the
  // undefined action: the request is taken and no packet comes out. All other rows
  // are checked against the packet model.
  typedef struct {
    logic [1:0]  action;
    logic [15:0] amplitude;
    logic [7:0]  depth_cm;
    logic [7:0]  confidence;
    logic [7:0]  target_kind;
    logic [15:0] voice_word;
    logic [15:0] magnitude;
    logic [15:0] pulse_value;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    bit          silent;
  } stim_row_t;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // target update: all zero, all ones, sign extremes, ignored fields loaded
    '{ACT_TARGET,  16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TARGET,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TARGET,  16'h8000, 8'h01, 8'h80, 8'h7F,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TARGET,  16'h7FFF, 8'h80, 8'h01, 8'hFE,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
    // voice trigger
    '{ACT_VOICE,   16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_VOICE,   16'h0000, 8'h00, 8'h00, 8'h00,
      16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_VOICE,   16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      16'hA55A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0},
    // spatial frame: zero, position extremes, truncation toward zero on both signs
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0},
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0},
    '{ACT_SPATIAL, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0},
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFD, 1'b0},
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0100, 1'b0},
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h1234, 16'hEDCB, 16'hFF00, 16'h0080, 1'b0},
    '{ACT_SPATIAL, 16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0100, 16'hFF00, 16'h0003, 16'hFF01, 1'b0},
    // undefined action, back to back: nothing may come out
    '{ACT_NONE,    16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
    '{ACT_NONE,    16'h0000, 8'h00, 8'h00, 8'h00,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
    '{ACT_TARGET,  16'h1234, 8'h56, 8'h78, 8'h9A,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Packet model
  // ---------------------------------------------------------------------------

  // Reflected CRC-16, fed one bit at a time, LSB first.
  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                    input logic [7:0] data);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int b = 0; b < 8; b++) begin
      feedback = acc[0] ^ data[b];
      acc = acc >> 1;
      if (feedback) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  // Q7.8 metres to centimetres: v * 100 / 256, truncated toward zero.
  // SV integer division on int already truncates toward zero.
  function automatic logic [15:0] q78_metres_to_cm(input logic [15:0] raw);
    int scaled;
    int cm;
    scaled = int'($signed(raw)) * 100;
    cm = scaled / 256;
    return cm[15:0];
  endfunction

  // Build the whole packet for one accepted request and queue its bytes.
  function automatic void build_frame(input request_t req);
    logic [7:0]  frame [FRAME_LEN];
    logic [7:0]  body [PAYLOAD_LEN];
    logic [15:0] crc;
    result_t     item;
    if (req.action == ACT_NONE) return;
    foreach (body[i]) body[i] = 8'h00;   // unused payload bytes are zero
    frame[0] = PKT_START;
    frame[1] = PKT_VERSION;
    frame[2] = 8'h00;
    case (req.action)
      ACT_TARGET: begin
        frame[2] = TYPE_TARGET;
        {body[1], body[0]} = req.amplitude;
        body[2] = req.depth_cm;
        body[3] = req.confidence;
        body[4] = req.target_kind;
      end
      ACT_VOICE: begin
        frame[2] = TYPE_VOICE;
        {body[1], body[0]} = req.voice_word;
      end
      ACT_SPATIAL: begin
        frame[2] = TYPE_SPATIAL;
        {body[1], body[0]} = req.magnitude;
        {body[3], body[2]} = req.pulse_value;
        {body[5], body[4]} = q78_metres_to_cm(req.pos_x);
        {body[7], body[6]} = q78_metres_to_cm(req.pos_y);
      end
      default: ;
    endcase
    // whitening: byte i XOR (0x5F + i) mod 256
    foreach (body[i]) frame[HDR_BYTES + i] = body[i] ^ 8'(XOR_BASE + i);
    crc = CRC_INIT;
    for (int i = 0; i < HDR_BYTES + PAYLOAD_LEN; i++) crc = crc16_modbus_byte(crc, frame[i]);
    frame[FRAME_LEN - 2] = crc[7:0];
    frame[FRAME_LEN - 1] = crc[15:8];
    for (int i = 0; i < FRAME_LEN; i++) begin
      item.tx_byte   = frame[i];
      item.last_byte = (i == FRAME_LEN - 1);
      packet_bytes_due.push_back(item);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // 16-bit value biased toward the signed extremes and the area around zero.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed frame kinds, with a few undefined actions as noise.
  function automatic request_t random_request();
    request_t req;
    req.action      = ($urandom_range(99) < 8) ? ACT_NONE : 2'($urandom_range(2));
    req.amplitude   = pick_word();
    req.depth_cm    = 8'($urandom);
    req.confidence  = 8'($urandom);
    req.target_kind = 8'($urandom);
    req.voice_word  = 16'($urandom);
    req.magnitude   = pick_word();
    req.pulse_value = pick_word();
    req.pos_x       = pick_word();
    req.pos_y       = pick_word();
    return req;
  endfunction

  // Present one request from a falling edge and hold it until a rising edge sees
  // busy low; that edge is the transaction. Start stays high into the next request
  // when the sender does not idle, so back-to-back transactions are exercised.
  task automatic send_request(input request_t req, input bit silent);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!silent) build_frame(req);
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t ns: mismatch, %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte checker: every strobed byte is compared with the oldest expectation.
  // Sampling at the rising edge sees the values the block held through the cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (packet_bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h last %b", result.tx_byte,
                                result.last_byte));
      end else begin
        want = packet_bytes_due.pop_front();
        if (result.tx_byte !== want.tx_byte)
          flag_mismatch($sformatf("byte %0d tx_byte expected %h got %h",
                                  bytes_seen, want.tx_byte, result.tx_byte));
        if (result.last_byte !== want.last_byte)
          flag_mismatch($sformatf("byte %0d last_byte expected %b got %b",
                                  bytes_seen, want.last_byte, result.last_byte));
      end
      bytes_seen++;
    end
  end

  // Watchdog: ends the run if no transaction and no byte happen for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    request_t    req;
    stim_row_t   row;
    int unsigned phase_gap [3];
    phase_gap[0]   = 24;
    phase_gap[1]   = 56;
    phase_gap[2]   = 0;     // sustained traffic, no idle cycles
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    gap_pct        = phase_gap[0];
    mismatch_count = 0;
    bytes_seen     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      req.action      = row.action;
      req.amplitude   = row.amplitude;
      req.depth_cm    = row.depth_cm;
      req.confidence  = row.confidence;
      req.target_kind = row.target_kind;
      req.voice_word  = row.voice_word;
      req.magnitude   = row.magnitude;
      req.pulse_value = row.pulse_value;
      req.pos_x       = row.pos_x;
      req.pos_y       = row.pos_y;
      send_request(req, row.silent);
    end

    // random traffic in three idle profiles
    foreach (phase_gap[p]) begin
      gap_pct = phase_gap[p];
      repeat (RANDOM_REQUESTS / 3) send_request(random_request(), 1'b0);
    end
    start <= 1'b0;

    // let queued packets drain, then watch a little longer for stray bytes
    while (packet_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && packet_bytes_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
